@@ sv/rdc_pkg.sv @@
// Shared types, widths and operation codes for the radix digit converter.
// No dependencies; used by rdc_dabble_stage and radix_digit_converter.
package rdc_pkg;

   localparam int OPER_W          = 2;
   localparam int OPND_W          = 63;
   localparam int CONV_W          = 60;
   localparam int MAX_BIN_DIGITS  = 19;
   localparam int DEC_DIGITS      = 19;
   localparam int BCD_W           = 4 * DEC_DIGITS;
   localparam int BIN_W           = OPND_W + 1;
   localparam int STEPS_PER_STAGE = 4;
   localparam int DABBLE_STAGES   = BIN_W / STEPS_PER_STAGE;
   // whole octal digits: 8 digits of 3 bits
   localparam int SUM_W           = 24;
   localparam int OCT_DIGITS      = 8;
   localparam int OCT_NUM_W       = 27;
   localparam int HALF_DIGITS     = 10;
   localparam int HALF_OCT        = 4;

   localparam logic [OPER_W-1:0] OP_TO_VALUE  = 2'd0;
   localparam logic [OPER_W-1:0] OP_TO_OCTAL  = 2'd1;
   localparam logic [OPER_W-1:0] OP_TO_BINARY = 2'd2;
   localparam logic [OPER_W-1:0] OP_UNUSED    = 2'd3;

   typedef struct packed {
      logic [OPER_W-1:0]         op;
      logic                      ovf;
      logic [MAX_BIN_DIGITS-1:0] bits;
      logic [BCD_W-1:0]          bcd;
      logic [BIN_W-1:0]          bin;
   } dab_type;

   function automatic logic [CONV_W-1:0] pow10(input int k);
      logic [CONV_W-1:0] p;
      p = CONV_W'(1);
      for (int j = 0; j < k; j++) p = p * CONV_W'(10);
      return p;
   endfunction

endpackage

@@ sv/rdc_dabble_stage.sv @@
// One registered stage of the binary-to-BCD shift-and-add-3 converter.
// Depends on rdc_pkg for the stage payload type and widths.
module rdc_dabble_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_vld,
   input  rdc_pkg::dab_type in_data,
   output logic            out_vld,
   output rdc_pkg::dab_type out_data
);
   import rdc_pkg::*;

   logic    vld_ff;
   dab_type data_ff;
   dab_type data_in;

   always_comb begin
      logic [BCD_W-1:0] bcd;
      logic [BIN_W-1:0] bin;
      bcd = in_data.bcd;
      bin = in_data.bin;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         for (int d = 0; d < DEC_DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
         {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
      end
      data_in     = in_data;
      data_in.bcd = bcd;
      data_in.bin = bin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
      if (adv) data_ff <= data_in;
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

@@ sv/radix_digit_converter.sv @@
// Top level of the radix digit converter: BCD pipeline plus weighting stages.
// Depends on rdc_pkg and rdc_dabble_stage.
//
// Usage:
//   req channel: req_tuser carries the operation code, req_tdata the operand.
//   rsp channel: rsp_tdata carries the converted number, rsp_tuser overflow.
//   Operation 0 weights the operand's decimal digits by 2^position, 1 does
//   the same and writes the octal digits of that sum as a decimal numeral,
//   2 writes the operand's bits as a decimal numeral (overflow and zero if
//   the operand needs more than 19 bits), 3 answers zero.
// Pipeline: 16 BCD stages of four shift-and-add-3 steps each, then four
//   weighting/summing stages.
// Throughput: one beat per cycle unless stalled; the pipeline is fully overlapped.
// Stall: when a result waits with rsp_tready low, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated.
// Reset: synchronous; clears all valid bits, the pipeline comes up empty.
module radix_digit_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] operand, [63] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [59:0] converted, [63:60] zero
   output logic [0:0]  rsp_tuser    // [0] overflow
);
   import rdc_pkg::*;

   logic adv;
   logic    dab_vld [DABBLE_STAGES+1];
   dab_type dab_data[DABBLE_STAGES+1];

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      dab_vld[0]       = req_tvalid;
      dab_data[0].op   = req_tuser;
      dab_data[0].ovf  = (req_tuser == OP_TO_BINARY) &&
                         (|req_tdata[OPND_W-1:MAX_BIN_DIGITS]);
      dab_data[0].bits = req_tdata[MAX_BIN_DIGITS-1:0];
      dab_data[0].bcd  = '0;
      dab_data[0].bin  = {1'b0, req_tdata[OPND_W-1:0]};
   end

   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dab
      rdc_dabble_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (dab_vld[g]),
         .in_data  (dab_data[g]),
         .out_vld  (dab_vld[g+1]),
         .out_data (dab_data[g+1])
      );
   end

   // stage A: split digit-weight sums and mode 2 numeral
   logic              a_vld_ff;
   logic [OPER_W-1:0] a_op_ff;
   logic              a_ovf_ff;
   logic [SUM_W-1:0]  a_slo_ff, a_shi_ff, a_slo_in, a_shi_in;
   logic [CONV_W-1:0] a_nlo_ff, a_nhi_ff, a_nlo_in, a_nhi_in;

   always_comb begin
      dab_type d;
      d = dab_data[DABBLE_STAGES];
      a_slo_in = '0;
      a_shi_in = '0;
      a_nlo_in = '0;
      a_nhi_in = '0;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (i < HALF_DIGITS) a_slo_in = a_slo_in + (SUM_W'(d.bcd[4*i +: 4]) << i);
         else                 a_shi_in = a_shi_in + (SUM_W'(d.bcd[4*i +: 4]) << i);
      end
      for (int i = 0; i < MAX_BIN_DIGITS; i++) begin
         if (d.bits[i]) begin
            if (i < HALF_DIGITS) a_nlo_in = a_nlo_in + pow10(i);
            else                 a_nhi_in = a_nhi_in + pow10(i);
         end
      end
   end

   // stage B: final sums
   logic              b_vld_ff;
   logic [OPER_W-1:0] b_op_ff;
   logic              b_ovf_ff;
   logic [SUM_W-1:0]  b_sum_ff;
   logic [CONV_W-1:0] b_num_ff;

   // stage C: octal digits to decimal place values
   logic                 c_vld_ff;
   logic [OPER_W-1:0]    c_op_ff;
   logic                 c_ovf_ff;
   logic [SUM_W-1:0]     c_sum_ff;
   logic [CONV_W-1:0]    c_num_ff;
   logic [OCT_NUM_W-1:0] c_olo_ff, c_ohi_ff, c_olo_in, c_ohi_in;

   always_comb begin
      logic [OCT_NUM_W-1:0] term;
      c_olo_in = '0;
      c_ohi_in = '0;
      for (int k = 0; k < OCT_DIGITS; k++) begin
         term = OCT_NUM_W'(b_sum_ff[3*k +: 3]) * OCT_NUM_W'(pow10(k));
         if (k < HALF_OCT) c_olo_in = c_olo_in + term;
         else              c_ohi_in = c_ohi_in + term;
      end
   end

   // stage D: output register
   logic              d_vld_ff;
   logic              d_ovf_ff;
   logic [OPER_W-1:0] d_op_ff;
   logic [CONV_W-1:0] d_conv_ff, d_conv_in;

   always_comb begin
      case (c_op_ff)
         OP_TO_VALUE:  d_conv_in = CONV_W'(c_sum_ff);
         OP_TO_OCTAL:  d_conv_in = CONV_W'(c_olo_ff + c_ohi_ff);
         OP_TO_BINARY: d_conv_in = c_ovf_ff ? '0 : c_num_ff;
         default:      d_conv_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= dab_vld[DABBLE_STAGES];
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
      if (adv) begin
         a_op_ff   <= dab_data[DABBLE_STAGES].op;
         a_ovf_ff  <= dab_data[DABBLE_STAGES].ovf;
         a_slo_ff  <= a_slo_in;
         a_shi_ff  <= a_shi_in;
         a_nlo_ff  <= a_nlo_in;
         a_nhi_ff  <= a_nhi_in;
         b_op_ff   <= a_op_ff;
         b_ovf_ff  <= a_ovf_ff;
         b_sum_ff  <= a_slo_ff + a_shi_ff;
         b_num_ff  <= a_nlo_ff + a_nhi_ff;
         c_op_ff   <= b_op_ff;
         c_ovf_ff  <= b_ovf_ff;
         c_sum_ff  <= b_sum_ff;
         c_num_ff  <= b_num_ff;
         c_olo_ff  <= c_olo_in;
         c_ohi_ff  <= c_ohi_in;
         d_op_ff   <= c_op_ff;
         d_ovf_ff  <= c_ovf_ff;
         d_conv_ff <= d_conv_in;
      end
   end

   assign rsp_tvalid = d_vld_ff;
   assign rsp_tdata  = {4'b0, d_conv_ff};
   assign rsp_tuser  = d_ovf_ff;

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("overflow beat with nonzero result");

   a_ovf_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> d_op_ff == OP_TO_BINARY)
      else $error("overflow outside binary mode");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

endmodule

@@ dv/tb_top.sv @@
// Testbench for radix_digit_converter: directed table plus random conversion requests,
// checked beat by beat against the table's expected values or an in-bench digit-weighting predictor.
// Depends on rdc_pkg and the radix_digit_converter RTL.
`timescale 1ns / 1ps

module tb_top;
   import rdc_pkg::*;

   typedef struct packed {
      logic [59:0] converted;
      logic        overflow;
   } conv_result_type;

   typedef struct {
      logic [1:0]  op;
      logic [62:0] operand;
      logic        typed;     // expected result given in the row
      logic [59:0] converted;
      logic        overflow;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   conv_result_type expected_q[$];
   int              mismatch_count = 0;
   bit              quiet_phase = 1'b0;
   bit              hold_off = 1'b0;
   bit              stim_done = 1'b0;
   stim_row_type    dir_rows[$];

   radix_digit_converter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // decimal digits weighted by 2^position
   function automatic logic [63:0] weigh_digits(logic [62:0] numeral);
      logic [63:0] n;
      logic [63:0] sum;
      logic [63:0] weight;
      n = 64'(numeral);
      sum = '0;
      weight = 64'd1;
      while (n != 0) begin
         sum += (n % 10) * weight;
         n /= 10;
         weight <<= 1;
      end
      return sum;
   endfunction

   function automatic logic [63:0] spell_in_base(logic [63:0] value, int base);
      logic [63:0] v;
      logic [63:0] numeral;
      logic [63:0] place;
      v = value;
      numeral = '0;
      place = 64'd1;
      while (v != 0) begin
         numeral += (v % base) * place;
         v /= base;
         place *= 10;
      end
      return numeral;
   endfunction

   function automatic conv_result_type convert(logic [1:0] op, logic [62:0] operand);
      conv_result_type r;
      logic [63:0]     full;
      full = '0;
      r.overflow = 1'b0;
      case (op)
         OP_TO_VALUE: full = weigh_digits(operand);
         OP_TO_OCTAL: full = spell_in_base(weigh_digits(operand), 8);
         OP_TO_BINARY: begin
            if (operand >= (63'd1 << MAX_BIN_DIGITS)) r.overflow = 1'b1;
            else full = spell_in_base(64'(operand), 2);
         end
         default: full = '0;
      endcase
      r.converted = full[59:0];
      return r;
   endfunction

   function automatic logic [62:0] rand_operand();
      logic [62:0] v;
      case ($urandom_range(0, 4))
         0: v = 63'($urandom_range(0, 1023));
         1: v = 63'({$urandom, $urandom});
         2: v = 63'({$urandom, $urandom}) >> $urandom_range(0, 62);
         3: v = 63'($urandom_range(0, (1 << 19) + 64));
         default: begin
            // numeral made of 0/1 digits, the well-formed case
            v = '0;
            repeat ($urandom_range(1, 19)) v = v * 10 + $urandom_range(0, 1);
         end
      endcase
      return v;
   endfunction

   task automatic send_beat(logic [1:0] op, logic [62:0] operand, conv_result_type expd);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, operand};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(expd);
   endtask

   task automatic add_row(logic [1:0] op, logic [62:0] operand, logic typed,
                          logic [59:0] converted, logic overflow);
      stim_row_type r;
      r.op = op; r.operand = operand; r.typed = typed;
      r.converted = converted; r.overflow = overflow;
      dir_rows.push_back(r);
   endtask

   initial begin
      conv_result_type expd;
      logic [1:0]      op;
      add_row(OP_TO_VALUE,  63'd0, 1'b1, 60'd0, 1'b0);
      add_row(OP_TO_VALUE,  63'd1011, 1'b1, 60'd11, 1'b0);
      add_row(OP_TO_VALUE,  63'd12, 1'b1, 60'd4, 1'b0);
      add_row(OP_TO_VALUE,  63'(64'd9999999999999999999 >> 1), 1'b0, '0, 1'b0);
      add_row(OP_TO_VALUE,  {63{1'b1}}, 1'b0, '0, 1'b0);
      add_row(OP_TO_VALUE,  63'd1111111111111111111, 1'b1, 60'd524287, 1'b0);
      add_row(OP_TO_OCTAL,  63'd0, 1'b1, 60'd0, 1'b0);
      add_row(OP_TO_OCTAL,  63'd1000, 1'b1, 60'd10, 1'b0);
      add_row(OP_TO_OCTAL,  63'd1111111111111111111, 1'b1, 60'd1777777, 1'b0);
      add_row(OP_TO_OCTAL,  {63{1'b1}}, 1'b0, '0, 1'b0);
      add_row(OP_TO_OCTAL,  63'd987654321, 1'b0, '0, 1'b0);
      add_row(OP_TO_BINARY, 63'd0, 1'b1, 60'd0, 1'b0);
      add_row(OP_TO_BINARY, 63'd5, 1'b1, 60'd101, 1'b0);
      add_row(OP_TO_BINARY, 63'd524287, 1'b1, 60'd1111111111111111111, 1'b0);
      add_row(OP_TO_BINARY, 63'd524288, 1'b1, 60'd0, 1'b1);
      add_row(OP_TO_BINARY, {63{1'b1}}, 1'b1, 60'd0, 1'b1);
      add_row(OP_TO_BINARY, 63'd1 << 62, 1'b1, 60'd0, 1'b1);
      add_row(OP_UNUSED, 63'd12345, 1'b1, 60'd0, 1'b0);
      add_row(OP_UNUSED, {63{1'b1}}, 1'b1, 60'd0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].typed) begin
            expd.converted = dir_rows[i].converted;
            expd.overflow = dir_rows[i].overflow;
         end else begin
            expd = convert(dir_rows[i].op, dir_rows[i].operand);
         end
         send_beat(dir_rows[i].op, dir_rows[i].operand, expd);
      end

      for (int n = 0; n < 530; n++) begin
         if (n == 80) hold_off = 1'b1;
         if (n == 450) quiet_phase = 1'b1;
         op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
         begin
            logic [62:0] v;
            v = rand_operand();
            send_beat(op, v, convert(op, v));
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: random stalls plus one long hold-off so the pipeline backs up
   initial begin
      int stall_cycles;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            stall_cycles = 0;
            while (stall_cycles < 60) begin
               @(posedge clock);
               stall_cycles++;
            end
            rsp_tready <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      conv_result_type expd;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: converted=%0d overflow=%0b",
                        rsp_tdata[59:0], rsp_tuser[0]);
         end else begin
            expd = expected_q.pop_front();
            if (rsp_tdata[59:0] !== expd.converted || rsp_tuser[0] !== expd.overflow ||
                rsp_tdata[63:60] !== 4'd0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected converted=%0d ovf=%0b, got %0d ovf=%0b",
                           expd.converted, expd.overflow, rsp_tdata, rsp_tuser[0]);
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
